// ----- design/ttip_pkg.sv -----
package ttip_pkg;

  localparam int CharW = 16;
  localparam int ValW  = 64;

  // number format register codes
  localparam logic [1:0] FMT_HEX      = 2'd0;
  localparam logic [1:0] FMT_SIGNED   = 2'd1;
  localparam logic [1:0] FMT_UNSIGNED = 2'd2;

  localparam logic [CharW-1:0] CH_SPACE = 16'h0020;
  localparam logic [CharW-1:0] CH_TAB   = 16'h0009;
  localparam logic [CharW-1:0] CH_CR    = 16'h000D;
  localparam logic [CharW-1:0] CH_PLUS  = 16'h002B;
  localparam logic [CharW-1:0] CH_MINUS = 16'h002D;
  localparam logic [CharW-1:0] CH_0     = 16'h0030;
  localparam logic [CharW-1:0] CH_9     = 16'h0039;
  localparam logic [CharW-1:0] CH_UA    = 16'h0041;
  localparam logic [CharW-1:0] CH_UF    = 16'h0046;
  localparam logic [CharW-1:0] CH_LA    = 16'h0061;
  localparam logic [CharW-1:0] CH_LF    = 16'h0066;
  localparam logic [CharW-1:0] CH_UX    = 16'h0058;
  localparam logic [CharW-1:0] CH_LX    = 16'h0078;

  typedef enum logic [2:0] {
    PH_LEAD,
    PH_ZERO,
    PH_BODY,
    PH_TRAIL,
    PH_ERROR
  } phase_t;

  typedef struct packed {
    logic [ValW-1:0] acc;
    logic            minus;
    logic            ok;
  } result_t;

endpackage

// ----- design/ttip_scan.sv -----
module ttip_scan (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         step,
  input  logic [ttip_pkg::CharW-1:0]   char_in,
  input  logic                         last,
  input  logic [1:0]                   fmt,
  output logic                         res_load,
  output ttip_pkg::result_t            res
);
  import ttip_pkg::*;

  phase_t          phase, phase_next;
  logic [ValW-1:0] acc, acc_next;
  logic            minus_seen, minus_next;
  logic            digit_seen, digit_next;

  logic            hex, sgn, blank, is_dig, is_x, is_sign, ovf;
  logic [3:0]      dval;
  logic [ValW-1:0] acc_dig;
  phase_t          ph_dig;

  always_comb begin
    hex     = (fmt == FMT_HEX);
    sgn     = (fmt == FMT_SIGNED);
    blank   = (char_in == CH_SPACE) || (char_in inside {[CH_TAB:CH_CR]});
    is_sign = sgn && ((char_in == CH_PLUS) || (char_in == CH_MINUS));
    is_x    = hex && ((char_in == CH_LX) || (char_in == CH_UX));
    is_dig  = 1'b0;
    dval    = char_in[3:0];
    if (char_in inside {[CH_0:CH_9]}) begin
      is_dig = 1'b1;
    end else if (hex && ((char_in inside {[CH_UA:CH_UF]}) ||
                         (char_in inside {[CH_LA:CH_LF]}))) begin
      is_dig = 1'b1;
      dval   = 4'(char_in[3:0] + 4'd9);
    end
    // hex digit that would push bits past the top is an error
    ovf = hex && (acc[ValW-1:ValW-4] != 4'd0);
    if (hex) begin
      acc_dig = {acc[ValW-5:0], dval};
    end else begin
      acc_dig = (acc << 3) + (acc << 1) + ValW'(dval);
    end
    ph_dig = ovf ? PH_ERROR : PH_BODY;
  end

  // next phase
  always_comb begin
    phase_next = phase;
    case (phase)
      PH_LEAD: begin
        if (blank) phase_next = PH_LEAD;
        else if (is_sign) phase_next = PH_BODY;
        else if (is_dig) phase_next = (hex && dval == 4'd0) ? PH_ZERO : PH_BODY;
        else phase_next = PH_ERROR;
      end
      PH_ZERO, PH_BODY: begin
        if (phase == PH_ZERO && is_x) phase_next = PH_BODY;
        else if (blank) phase_next = PH_TRAIL;
        else if (is_dig) phase_next = ph_dig;
        else phase_next = PH_ERROR;
      end
      PH_TRAIL: begin
        if (!blank) phase_next = PH_ERROR;
      end
      default: phase_next = PH_ERROR;
    endcase
  end

  // datapath updates
  always_comb begin
    acc_next   = acc;
    minus_next = minus_seen;
    digit_next = digit_seen;
    case (phase)
      PH_LEAD: begin
        if (!blank && is_sign) begin
          minus_next = (char_in == CH_MINUS);
        end else if (!blank && is_dig) begin
          acc_next   = acc_dig;
          digit_next = 1'b1;
        end
      end
      PH_ZERO, PH_BODY: begin
        if (phase == PH_ZERO && is_x) begin
          acc_next   = '0;
          digit_next = 1'b0;
        end else if (!blank && is_dig && !ovf) begin
          acc_next   = acc_dig;
          digit_next = 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    res_load  = step && last;
    res.acc   = acc_next;
    res.minus = minus_next;
    res.ok    = digit_next && (phase_next == PH_ZERO || phase_next == PH_BODY ||
                               phase_next == PH_TRAIL);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= PH_LEAD;
      acc        <= '0;
      minus_seen <= 1'b0;
      digit_seen <= 1'b0;
    end else if (step) begin
      if (last) begin
        phase      <= PH_LEAD;
        acc        <= '0;
        minus_seen <= 1'b0;
        digit_seen <= 1'b0;
      end else begin
        phase      <= phase_next;
        acc        <= acc_next;
        minus_seen <= minus_next;
        digit_seen <= digit_next;
      end
    end
  end

  a_clear_after_last: assert property (@(posedge clk) disable iff (rst)
    step && last |=> phase == PH_LEAD && acc == '0 && !minus_seen && !digit_seen)
    else $error("scan state not cleared after last word");

  a_zero_phase: assert property (@(posedge clk) disable iff (rst)
    phase == PH_ZERO |-> acc == '0 && digit_seen)
    else $error("lone zero phase with nonzero value");

  a_sign_after_lead: assert property (@(posedge clk) disable iff (rst)
    minus_seen |-> phase != PH_LEAD)
    else $error("minus flag set while still in leading blanks");

endmodule

// ----- design/ttip_out.sv -----
module ttip_out (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         res_load,
  input  ttip_pkg::result_t            res_in,
  output logic                         m_tvalid,
  input  logic                         m_tready,
  output logic [ttip_pkg::ValW-1:0]    m_tdata,
  output logic                         m_tuser
);
  import ttip_pkg::*;

  result_t res;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (res_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      res <= res_in;
    end
  end

  // two's complement on a minus sign, zero when malformed
  always_comb begin
    if (!res.ok) begin
      m_tdata = '0;
    end else if (res.minus) begin
      m_tdata = (~res.acc) + ValW'(1);
    end else begin
      m_tdata = res.acc;
    end
    m_tuser = res.ok;
  end

endmodule

// ----- design/text_to_integer_parser_unit.sv -----
// channel | dir | tdata                  | tuser     | tlast
// s_*     | in  | [15:0] text_char       | -         | end_of_text
// m_*     | out | [63:0] parsed_value    | parse_ok  | -
// cfg_*   | in  | [1:0] number_format    | -         | -
//
// one word accepted per cycle, except while a last word waits for the result register
// m_tvalid rises when a last word moves from the input register into the result register
// rst is synchronous: format goes to hex, scan goes to leading blanks
// a stall on m_tready holds a last word; earlier words flow, later words wait
module text_to_integer_parser_unit (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         s_tvalid,
  output logic                         s_tready,
  input  logic [ttip_pkg::CharW-1:0]   s_tdata,   // [15:0] text_char
  input  logic                         s_tlast,
  output logic                         m_tvalid,
  input  logic                         m_tready,
  output logic [ttip_pkg::ValW-1:0]    m_tdata,   // [63:0] parsed_value
  output logic                         m_tuser,   // [0] parse_ok
  input  logic                         cfg_we,
  input  logic [1:0]                   cfg_wdata
);
  import ttip_pkg::*;

  logic [1:0]       fmt;
  logic             in_valid;
  logic [CharW-1:0] in_char;
  logic             in_last;
  logic             in_adv, res_free, res_load;
  result_t          res;

  always_ff @(posedge clk) begin
    if (rst) begin
      fmt <= FMT_HEX;
    end else if (cfg_we) begin
      fmt <= cfg_wdata;
    end
  end

  // a last word needs the result register free to move on
  assign res_free = !m_tvalid || m_tready;
  assign in_adv   = in_valid && (!in_last || res_free);
  assign s_tready = !in_valid || in_adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      in_char <= s_tdata;
      in_last <= s_tlast;
    end
  end

  ttip_scan u_scan (
    .clk      (clk),
    .rst      (rst),
    .step     (in_adv),
    .char_in  (in_char),
    .last     (in_last),
    .fmt      (fmt),
    .res_load (res_load),
    .res      (res)
  );

  ttip_out u_out (
    .clk      (clk),
    .rst      (rst),
    .res_load (res_load),
    .res_in   (res),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

endmodule

// ----- test/tb_text_to_integer_parser_unit.sv -----
module tb_text_to_integer_parser_unit;
  import ttip_pkg::*;

  localparam int StallLimit = 4000;
  localparam int LongHold   = 400;
  localparam int RandWords  = 1150;

  typedef struct packed {
    logic [ValW-1:0] value;
    logic            ok;
  } parse_result_t;

  typedef struct packed {
    logic          given;
    parse_result_t res;
  } typed_result_t;

  typedef struct {
    logic [1:0]       f;
    string            txt;
    logic [CharW-1:0] tail;
    logic             typed;
    logic [ValW-1:0]  value;
    logic             ok;
  } probe_row_t;

  logic             clk       = 1'b0;
  logic             rst       = 1'b1;
  logic             s_tvalid  = 1'b0;
  logic             s_tready;
  logic [CharW-1:0] s_tdata   = '0;
  logic             s_tlast   = 1'b0;
  logic             m_tvalid;
  logic             m_tready  = 1'b0;
  logic [ValW-1:0]  m_tdata;
  logic             m_tuser;
  logic             cfg_we    = 1'b0;
  logic [1:0]       cfg_wdata = '0;

  // predictor state
  logic [1:0]      fmt_now = FMT_HEX;
  phase_t          scan_ph = PH_LEAD;
  logic [ValW-1:0] scan_acc = '0;
  logic            scan_neg = 1'b0;
  logic            scan_digit = 1'b0;

  parse_result_t    results_due[$];
  typed_result_t    given_due[$];
  logic [CharW-1:0] text_buf[$];
  probe_row_t       probes[$];

  int fails = 0;
  int words_sent = 0;
  int burst_left = 0;
  logic gaps_on = 1'b1;
  int hold_ask = 0;

  text_to_integer_parser_unit dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic logic is_blank(input logic [CharW-1:0] c);
    return c == CH_SPACE || (c >= CH_TAB && c <= CH_CR);
  endfunction

  // 16 means not a digit in this mode
  function automatic logic [4:0] digit_value(input logic [CharW-1:0] c, input logic hex);
    if (c >= CH_0 && c <= CH_9) return 5'(c - CH_0);
    if (hex && c >= CH_UA && c <= CH_UF) return 5'(c - CH_UA + 10);
    if (hex && c >= CH_LA && c <= CH_LF) return 5'(c - CH_LA + 10);
    return 5'd16;
  endfunction

  task automatic clear_scan();
    scan_ph = PH_LEAD;
    scan_acc = '0;
    scan_neg = 1'b0;
    scan_digit = 1'b0;
  endtask

  task automatic shift_in_digit(input logic [3:0] d, input logic hex);
    if (hex) begin
      // a nonzero top nibble would fall off the top
      if (scan_acc[63:60] != 4'h0) begin
        scan_ph = PH_ERROR;
        return;
      end
      scan_acc = {scan_acc[59:0], 4'h0} + ValW'(d);
    end else begin
      scan_acc = scan_acc * 64'd10 + ValW'(d);
    end
    scan_digit = 1'b1;
    scan_ph = PH_BODY;
  endtask

  task automatic advance_scan(input logic [CharW-1:0] c);
    logic hex;
    logic sgn;
    logic [4:0] d;
    hex = (fmt_now == FMT_HEX);
    sgn = (fmt_now == FMT_SIGNED);
    d = digit_value(c, hex);
    case (scan_ph)
      PH_LEAD: begin
        if (is_blank(c)) begin
        end else if (sgn && (c == CH_PLUS || c == CH_MINUS)) begin
          scan_neg = (c == CH_MINUS);
          scan_ph = PH_BODY;
        end else if (d < 5'd16) begin
          shift_in_digit(d[3:0], hex);
          if (hex && d == 5'd0) scan_ph = PH_ZERO;
        end else begin
          scan_ph = PH_ERROR;
        end
      end
      PH_ZERO, PH_BODY: begin
        if (scan_ph == PH_ZERO && hex && (c == CH_LX || c == CH_UX)) begin
          scan_digit = 1'b0;
          scan_acc = '0;
          scan_ph = PH_BODY;
        end else if (is_blank(c)) begin
          scan_ph = PH_TRAIL;
        end else if (d < 5'd16) begin
          shift_in_digit(d[3:0], hex);
        end else begin
          scan_ph = PH_ERROR;
        end
      end
      PH_TRAIL: begin
        if (!is_blank(c)) scan_ph = PH_ERROR;
      end
      default: scan_ph = PH_ERROR;
    endcase
  endtask

  task automatic close_scan(output parse_result_t r);
    logic good;
    logic [ValW-1:0] v;
    good = scan_digit && (scan_ph == PH_ZERO || scan_ph == PH_BODY || scan_ph == PH_TRAIL);
    v = scan_neg ? (~scan_acc + 64'd1) : scan_acc;
    r.value = good ? v : '0;
    r.ok = good;
    clear_scan();
  endtask

  always @(posedge clk) begin : scoreboard
    parse_result_t want;
    typed_result_t pin;
    if (rst) begin
      clear_scan();
      fmt_now = FMT_HEX;
    end else begin
      if (cfg_we) fmt_now = cfg_wdata;
      if (m_tvalid && m_tready) begin
        if (results_due.size() == 0) begin
          $error("result with none due: parsed_value %h parse_ok %b", m_tdata, m_tuser);
          fails++;
        end else begin
          want = results_due.pop_front();
          if (m_tdata !== want.value) begin
            $error("parsed_value expected %h actual %h", want.value, m_tdata);
            fails++;
          end
          if (m_tuser !== want.ok) begin
            $error("parse_ok expected %b actual %b", want.ok, m_tuser);
            fails++;
          end
        end
      end
      if (s_tvalid && s_tready) begin
        advance_scan(s_tdata);
        if (s_tlast) begin
          close_scan(want);
          if (given_due.size() != 0) begin
            pin = given_due.pop_front();
            if (pin.given) want = pin.res;
          end
          results_due.push_back(want);
        end
      end
    end
  end

  always @(posedge clk) begin : watchdog
    int idle_cycles;
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= StallLimit) begin
        $display("Some tests failed");
        $finish;
      end
    end
  end

  // receiver: rotating ready pattern, reshuffled now and then, plus long hold-offs on request
  initial begin : rx_side
    logic [15:0] pat;
    int hold_left;
    int served;
    int tick;
    pat = 16'hFFFF;
    hold_left = 0;
    served = 0;
    tick = 0;
    forever begin
      @(posedge clk);
      tick++;
      if (hold_left > 0) begin
        hold_left--;
        m_tready <= 1'b0;
      end else if (served != hold_ask) begin
        served++;
        hold_left = LongHold;
        m_tready <= 1'b0;
      end else begin
        if (tick % 97 == 0)
          pat = ($urandom_range(0, 2) == 0) ? 16'hFFFF : (16'($urandom) | 16'h0001);
        m_tready <= pat[0];
        pat = {pat[0], pat[15:1]};
      end
    end
  end

  task automatic put_word(input logic [CharW-1:0] c, input logic l);
    if (gaps_on && burst_left == 0) begin
      burst_left = $urandom_range(1, 20);
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    if (burst_left > 0) burst_left--;
    s_tvalid <= 1'b1;
    s_tdata <= c;
    s_tlast <= l;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    words_sent++;
  endtask

  task automatic send_text();
    for (int i = 0; i < text_buf.size(); i++)
      put_word(text_buf[i], i == text_buf.size() - 1);
  endtask

  // only while idle: drain results, let the pipe settle, then write
  task automatic write_format(input logic [1:0] f);
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (results_due.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= f;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  function automatic logic [CharW-1:0] pick_blank();
    if ($urandom_range(0, 2) == 0) return CH_SPACE;
    return CharW'(CH_TAB + $urandom_range(0, 4));
  endfunction

  function automatic logic [CharW-1:0] pick_digit(input logic hex);
    int r;
    if (!hex) return CharW'(CH_0 + $urandom_range(0, 9));
    r = $urandom_range(0, 21);
    if (r < 10) return CharW'(CH_0 + r);
    if (r < 16) return CharW'(CH_UA + r - 10);
    return CharW'(CH_LA + r - 16);
  endfunction

  task automatic build_random_text(input logic [1:0] f);
    int kind;
    int n;
    logic hex;
    logic [CharW-1:0] junk;
    hex = (f == FMT_HEX);
    text_buf.delete();
    kind = $urandom_range(0, 9);
    repeat ($urandom_range(0, 2)) text_buf.push_back(pick_blank());
    if (kind == 9) begin
      // noise over the whole code unit range
      repeat ($urandom_range(1, 6)) text_buf.push_back(CharW'($urandom));
    end else begin
      if (f == FMT_SIGNED ? $urandom_range(0, 1) == 1 : $urandom_range(0, 15) == 0)
        text_buf.push_back($urandom_range(0, 1) ? CH_MINUS : CH_PLUS);
      if (hex && $urandom_range(0, 1) == 1) begin
        text_buf.push_back(CH_0);
        text_buf.push_back($urandom_range(0, 1) ? CH_LX : CH_UX);
      end
      if (kind == 8) n = 0;
      else if ($urandom_range(0, 1) == 1) n = $urandom_range(1, 4);
      else n = hex ? $urandom_range(12, 17) : $urandom_range(15, 21);
      repeat (n) text_buf.push_back(pick_digit(hex));
      repeat ($urandom_range(0, 2)) text_buf.push_back(pick_blank());
      if (kind >= 6) begin
        // one stray word somewhere in the string
        case ($urandom_range(0, 2))
          0: junk = CharW'($urandom);
          1: junk = CharW'($urandom_range(0, 127));
          default: junk = pick_blank();
        endcase
        text_buf.insert($urandom_range(0, text_buf.size()), junk);
      end
    end
    if (text_buf.size() == 0) text_buf.push_back(pick_blank());
  endtask

  initial begin : stimulus
    logic [1:0] f;
    probe_row_t row;
    typed_result_t pin;
    int strings_left;

    probes.push_back('{FMT_HEX, "0", 16'h0, 1'b1, 64'h0, 1'b1});
    probes.push_back('{FMT_HEX, "FFFFFFFFFFFFFFFF", 16'h0, 1'b1, '1, 1'b1});
    probes.push_back('{FMT_HEX, "0x10000000000000000", 16'h0, 1'b1, 64'h0, 1'b0});
    probes.push_back('{FMT_HEX, "  0x1aF \t", 16'h0, 1'b0, 64'h0, 1'b0});
    probes.push_back('{FMT_HEX, "0X", 16'h0, 1'b1, 64'h0, 1'b0});
    probes.push_back('{FMT_HEX, "00x1", 16'h0, 1'b0, 64'h0, 1'b0});
    probes.push_back('{FMT_HEX, "  \n", 16'h0, 1'b1, 64'h0, 1'b0});
    probes.push_back('{FMT_HEX, "1 2", 16'h0, 1'b1, 64'h0, 1'b0});
    probes.push_back('{FMT_HEX, "12", 16'hFFFF, 1'b1, 64'h0, 1'b0});
    probes.push_back('{FMT_HEX, "-5", 16'h0, 1'b1, 64'h0, 1'b0});
    probes.push_back('{FMT_HEX, "0 ", 16'h0, 1'b0, 64'h0, 1'b0});
    probes.push_back('{FMT_SIGNED, "-1", 16'h0, 1'b1, '1, 1'b1});
    probes.push_back('{FMT_SIGNED, "+18446744073709551615", 16'h0, 1'b1, '1, 1'b1});
    probes.push_back('{FMT_SIGNED, "18446744073709551616", 16'h0, 1'b1, 64'h0, 1'b1});
    probes.push_back('{FMT_SIGNED, "-", 16'h0, 1'b1, 64'h0, 1'b0});
    probes.push_back('{FMT_SIGNED, " -9223372036854775808 ", 16'h0, 1'b0, 64'h0, 1'b0});
    probes.push_back('{FMT_SIGNED, "0x5", 16'h0, 1'b1, 64'h0, 1'b0});
    probes.push_back('{FMT_SIGNED, "+-1", 16'h0, 1'b1, 64'h0, 1'b0});
    probes.push_back('{FMT_UNSIGNED, "18446744073709551615", 16'h0, 1'b1, '1, 1'b1});
    probes.push_back('{FMT_UNSIGNED, "+7", 16'h0, 1'b1, 64'h0, 1'b0});
    probes.push_back('{FMT_UNSIGNED, "\t42\r", 16'h0, 1'b0, 64'h0, 1'b0});
    probes.push_back('{FMT_UNSIGNED, "abc", 16'h0, 1'b1, 64'h0, 1'b0});
    // unused format code behaves as unsigned decimal
    probes.push_back('{2'd3, "99", 16'h0, 1'b0, 64'h0, 1'b0});
    probes.push_back('{2'd3, "-1", 16'h0, 1'b1, 64'h0, 1'b0});

    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    gaps_on = 1'b1;
    for (int r = 0; r < probes.size(); r++) begin
      row = probes[r];
      if (r == 0 || row.f != probes[r-1].f) write_format(row.f);
      text_buf.delete();
      for (int i = 0; i < row.txt.len(); i++) text_buf.push_back(CharW'(row.txt[i]));
      if (row.tail != 16'h0) text_buf.push_back(row.tail);
      pin.given = row.typed;
      pin.res.value = row.value;
      pin.res.ok = row.ok;
      given_due.push_back(pin);
      send_text();
    end

    for (int ph = 0; words_sent < RandWords; ph++) begin
      f = (ph < 4) ? 2'(ph) : 2'($urandom_range(0, 3));
      write_format(f);
      gaps_on = ($urandom_range(0, 3) != 0);
      strings_left = $urandom_range(3, 12);
      if (ph == 1) begin
        // long receiver hold-off while the sender keeps pushing words
        hold_ask <= hold_ask + 1;
        gaps_on = 1'b0;
        strings_left = 12;
      end
      while (strings_left > 0 && words_sent < RandWords) begin
        build_random_text(f);
        send_text();
        strings_left--;
      end
    end

    s_tvalid <= 1'b0;
    @(posedge clk);
    while (results_due.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (fails == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end

endmodule
